// File: rtl/rmq_pkg.sv
// Shared types, lane codes and bit-search helpers for the rotation matrix to
// quaternion pipeline. No dependencies.
`default_nettype none

package rmq_pkg;

    localparam int OUT_FRAC_DEF = 30;
    localparam int WORK_FRAC    = 30;

    // Quaternion slots; the branch code names the slot that gets the root term
    localparam logic [1:0] LANE_X = 2'd0;
    localparam logic [1:0] LANE_Y = 2'd1;
    localparam logic [1:0] LANE_Z = 2'd2;
    localparam logic [1:0] LANE_W = 2'd3;

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m02;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
    } rmq_in_t;

    typedef struct packed {
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic signed [31:0] qz;
        logic signed [31:0] qw;
        logic               degenerate;
    } rmq_out_t;

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [6:0] lzc64(input logic [63:0] v);
        logic [6:0] n;
        logic       hit;
        n   = 7'd64;
        hit = 1'b0;
        for (int i = 63; i >= 0; i--)
        begin
            if (!hit && v[i])
            begin
                n   = 7'(63 - i);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// File: rtl/rotation_matrix_to_quaternion_top.sv
// Rotation matrix to unit quaternion (Shepperd), fully pipelined top level.
// Depends on rmq_pkg, rmq_uscale, rmq_isqrt and rmq_div.
//
//   channel  | handshake      | payload
//   ---------+----------------+---------------------------------------
//   request  | start / busy   | matrix : rmq_in_t, nine Q16.16 entries
//   result   | done (strobe)  | result : rmq_out_t, Q2.30 quaternion
//
// One request enters per cycle; busy stays low. Each result shows on done
// for one cycle, in order. The depth comes from three 32-stage root
// pipelines (column scale, branch root, final scale) and the bit-per-stage
// dividers (31, 46 and OUT_FRAC_BITS+1 stages).
// Reset clears only the valid bits; nothing ever stalls inside.
`default_nettype none

module rotation_matrix_to_quaternion_top
    import rmq_pkg::*;
#(
    parameter int OUT_FRAC_BITS = OUT_FRAC_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          start,
    output logic         busy,
    input  wire rmq_in_t matrix,
    output logic         done,
    output rmq_out_t     result
);

    localparam int          F       = OUT_FRAC_BITS;
    localparam logic [31:0] Q_ONE   = 32'(64'd1 << OUT_FRAC_BITS);
    localparam logic signed [33:0] ONE_Q30 = 34'sd1 <<< WORK_FRAC;

    // ---------------- stage 0..2: magnitudes, squares, column lengths
    logic        v0_reg, v1_reg, v2_reg;
    rmq_in_t     m0_reg;
    logic [31:0] ent  [9];
    logic [31:0] mag1_reg [9];
    logic [8:0]  sgn1_reg;
    logic [63:0] sq1_reg  [9];
    logic [31:0] mag2_reg [9];
    logic [8:0]  sgn2_reg;
    logic [63:0] cl2_reg  [3];
    logic        deg2_reg;
    logic [63:0] cl2_next [3];

    function automatic logic [31:0] matrix_bits(input logic signed [31:0] v);
        return v;
    endfunction

    always_comb
    begin
        ent[0] = matrix_bits(m0_reg.m00);
        ent[1] = matrix_bits(m0_reg.m01);
        ent[2] = matrix_bits(m0_reg.m02);
        ent[3] = matrix_bits(m0_reg.m10);
        ent[4] = matrix_bits(m0_reg.m11);
        ent[5] = matrix_bits(m0_reg.m12);
        ent[6] = matrix_bits(m0_reg.m20);
        ent[7] = matrix_bits(m0_reg.m21);
        ent[8] = matrix_bits(m0_reg.m22);
        for (int j = 0; j < 3; j++)
            cl2_next[j] = sq1_reg[j] + sq1_reg[3+j] + sq1_reg[6+j];
    end

    always_ff @(posedge clk)
    begin
        m0_reg <= matrix;
        for (int i = 0; i < 9; i++)
        begin
            mag1_reg[i] <= abs32(ent[i]);
            sgn1_reg[i] <= ent[i][31];
            sq1_reg[i]  <= 64'(abs32(ent[i])) * 64'(abs32(ent[i]));
            mag2_reg[i] <= mag1_reg[i];
        end
        sgn2_reg <= sgn1_reg;
        for (int j = 0; j < 3; j++)
            cl2_reg[j] <= cl2_next[j];
        deg2_reg <= (cl2_next[0] == 64'd0) || (cl2_next[1] == 64'd0) ||
                    (cl2_next[2] == 64'd0);
    end

    // ---------------- column scaling
    logic [2:0][31:0] col_mag  [3];
    logic             col_vld  [3];
    logic [2:0][30:0] col_val  [3];
    logic [3:0]       col_side [3];

    genvar gc;
    generate
        for (gc = 0; gc < 3; gc++)
        begin : g_col
            assign col_mag[gc] = {mag2_reg[6+gc], mag2_reg[3+gc], mag2_reg[gc]};

            rmq_uscale #(
                .N  (3),
                .AW (32),
                .F  (WORK_FRAC),
                .SW (4)
            ) u_col (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (v2_reg),
                .in_len    (cl2_reg[gc]),
                .in_mag    (col_mag[gc]),
                .in_side   ({deg2_reg, sgn2_reg[6+gc], sgn2_reg[3+gc], sgn2_reg[gc]}),
                .out_valid (col_vld[gc]),
                .out_val   (col_val[gc]),
                .out_side  (col_side[gc])
            );
        end
    endgenerate

    // ---------------- stage 3: branch choice, radicand, differences
    logic signed [33:0] rv [9];
    logic signed [33:0] tr;
    logic signed [33:0] rad3_next;
    logic signed [33:0] d3 [4];
    logic [1:0]         br3_next;
    logic [3:0][31:0]   dmag3_next;
    logic [3:0]         dsgn3_next;

    logic               v3_reg;
    logic signed [33:0] rad3_reg;
    logic [3:0][31:0]   dmag3_reg;
    logic [3:0]         dsgn3_reg;
    logic [1:0]         br3_reg;
    logic               deg3_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (col_side[j][i])
                    rv[i*3+j] = -$signed({3'b000, col_val[j][i]});
                else
                    rv[i*3+j] = $signed({3'b000, col_val[j][i]});
            end
        end
        tr = rv[0] + rv[4] + rv[8];
        for (int l = 0; l < 4; l++)
            d3[l] = '0;
        if (tr > 0)
        begin
            br3_next     = LANE_W;
            rad3_next    = tr + ONE_Q30;
            d3[LANE_X]   = rv[7] - rv[5];
            d3[LANE_Y]   = rv[2] - rv[6];
            d3[LANE_Z]   = rv[3] - rv[1];
        end
        else if (rv[0] > rv[4] && rv[0] > rv[8])
        begin
            br3_next     = LANE_X;
            rad3_next    = ONE_Q30 + rv[0] - rv[4] - rv[8];
            d3[LANE_W]   = rv[7] - rv[5];
            d3[LANE_Y]   = rv[1] + rv[3];
            d3[LANE_Z]   = rv[2] + rv[6];
        end
        else if (rv[4] > rv[8])
        begin
            br3_next     = LANE_Y;
            rad3_next    = ONE_Q30 + rv[4] - rv[0] - rv[8];
            d3[LANE_W]   = rv[2] - rv[6];
            d3[LANE_X]   = rv[1] + rv[3];
            d3[LANE_Z]   = rv[5] + rv[7];
        end
        else
        begin
            br3_next     = LANE_Z;
            rad3_next    = ONE_Q30 + rv[8] - rv[0] - rv[4];
            d3[LANE_W]   = rv[3] - rv[1];
            d3[LANE_X]   = rv[2] + rv[6];
            d3[LANE_Y]   = rv[5] + rv[7];
        end
        for (int l = 0; l < 4; l++)
        begin
            dsgn3_next[l] = d3[l][33];
            dmag3_next[l] = d3[l][33] ? 32'(-d3[l]) : 32'(d3[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        rad3_reg  <= rad3_next;
        dmag3_reg <= dmag3_next;
        dsgn3_reg <= dsgn3_next;
        br3_reg   <= br3_next;
        deg3_reg  <= col_side[0][3];
    end

    // ---------------- branch root s = 2*sqrt(rad << 30)
    logic [63:0]  br_rad;
    logic         brs_vld;
    logic [31:0]  brs_root;
    logic [134:0] brs_side;

    assign br_rad = (rad3_reg > 0) ? {rad3_reg[33:0], 30'b0} : 64'd0;

    rmq_isqrt #(
        .IW (64),
        .SW (135)
    ) u_brsqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .in_val    (br_rad),
        .in_side   ({deg3_reg, dsgn3_reg, br3_reg, dmag3_reg}),
        .out_valid (brs_vld),
        .out_root  (brs_root),
        .out_side  (brs_side)
    );

    // ---------------- stage 5: numerators for the four divider lanes (the root lane's quotient goes unused)
    logic [3:0][31:0] dmag5;
    logic [32:0]      s5;
    logic [3:0][61:0] num5_next;
    logic [33:0]      diag_sum;

    logic             v5_reg;
    logic [3:0][61:0] num5_reg;
    logic [32:0]      s5_reg;
    logic [39:0]      side5_reg;

    always_comb
    begin
        dmag5    = brs_side[127:0];
        s5       = {brs_root, 1'b0};
        diag_sum = 34'(s5) + 34'd2;
        for (int l = 0; l < 4; l++)
            num5_next[l] = {dmag5[l], 30'b0} + 62'(brs_root);
    end

    always_ff @(posedge clk)
    begin
        num5_reg  <= num5_next;
        s5_reg    <= s5;
        // deg, signs, branch, zero root, root term
        side5_reg <= {brs_side[134:128], (brs_root == 32'd0), diag_sum[33:2]};
    end

    logic             dv_vld;
    logic [3:0][45:0] dv_quo;
    logic [39:0]      dv_side;

    rmq_div #(
        .LANES (4),
        .NW    (62),
        .DW    (33),
        .QW    (46),
        .SW    (40)
    ) u_brdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .in_num    (num5_reg),
        .in_den    (s5_reg),
        .in_side   (side5_reg),
        .out_valid (dv_vld),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    // ---------------- stages 6..11: pick components, renormalize, sum squares
    logic [1:0]  dv_br;
    logic [3:0]  dv_sgn;
    logic [45:0] mg6_next [4];
    logic [3:0]  sgn6_next;

    logic        v6_reg, v7_reg, v8_reg, v9_reg, v10_reg, v11_reg;
    logic [45:0] mg6_reg [4];
    logic [45:0] mg7_reg [4];
    logic [45:0] mg8_reg [4];
    logic [3:0]  sgn6_reg, sgn7_reg, sgn8_reg, sgn9_reg, sgn10_reg, sgn11_reg;
    logic        deg6_reg, deg7_reg, deg8_reg, deg9_reg, deg10_reg, deg11_reg;
    logic [45:0] big7_reg;
    logic [5:0]  p8_reg;
    logic [30:0] mg9_reg  [4];
    logic [30:0] mg10_reg [4];
    logic [61:0] sq10_reg [4];
    logic [3:0][30:0] mg11_reg;
    logic [63:0] len11_reg;

    logic [45:0] b01, b23, big7_next;
    logic [6:0]  lz8;
    logic [45:0] sh9;
    logic [30:0] mg9_next [4];

    assign dv_br  = dv_side[34:33];
    assign dv_sgn = dv_side[38:35];

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            if (dv_br == 2'(l))
            begin
                mg6_next[l]  = 46'(dv_side[31:0]);
                sgn6_next[l] = 1'b0;
            end
            else
            begin
                mg6_next[l]  = dv_side[32] ? 46'd0 : dv_quo[l];
                sgn6_next[l] = dv_sgn[l];
            end
        end
        b01       = (mg6_reg[0] > mg6_reg[1]) ? mg6_reg[0] : mg6_reg[1];
        b23       = (mg6_reg[2] > mg6_reg[3]) ? mg6_reg[2] : mg6_reg[3];
        big7_next = (b01 > b23) ? b01 : b23;
        lz8       = lzc64(64'(big7_reg));
        for (int l = 0; l < 4; l++)
        begin
            // bring the largest component into [2^30, 2^31)
            if (p8_reg >= 6'd31)
                sh9 = mg8_reg[l] >> (p8_reg - 6'd30);
            else
                sh9 = mg8_reg[l] << (6'd30 - p8_reg);
            mg9_next[l] = sh9[30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 4; l++)
        begin
            mg6_reg[l]  <= mg6_next[l];
            mg7_reg[l]  <= mg6_reg[l];
            mg8_reg[l]  <= mg7_reg[l];
            mg9_reg[l]  <= mg9_next[l];
            mg10_reg[l] <= mg9_reg[l];
            sq10_reg[l] <= 62'(mg9_reg[l]) * 62'(mg9_reg[l]);
            mg11_reg[l] <= mg10_reg[l];
        end
        sgn6_reg  <= sgn6_next;
        sgn7_reg  <= sgn6_reg;
        sgn8_reg  <= sgn7_reg;
        sgn9_reg  <= sgn8_reg;
        sgn10_reg <= sgn9_reg;
        sgn11_reg <= sgn10_reg;
        deg6_reg  <= dv_side[39];
        deg7_reg  <= deg6_reg || (big7_next == 46'd0);
        deg8_reg  <= deg7_reg;
        deg9_reg  <= deg8_reg;
        deg10_reg <= deg9_reg;
        deg11_reg <= deg10_reg;
        big7_reg  <= big7_next;
        p8_reg    <= 6'(7'd63 - lz8);
        len11_reg <= 64'(sq10_reg[0]) + 64'(sq10_reg[1]) +
                     64'(sq10_reg[2]) + 64'(sq10_reg[3]);
    end

    // ---------------- final scaling to unit length
    logic              fs_vld;
    logic [3:0][F:0]   fs_val;
    logic [4:0]        fs_side;

    rmq_uscale #(
        .N  (4),
        .AW (31),
        .F  (F),
        .SW (5)
    ) u_final (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v11_reg),
        .in_len    (len11_reg),
        .in_mag    (mg11_reg),
        .in_side   ({deg11_reg, sgn11_reg}),
        .out_valid (fs_vld),
        .out_val   (fs_val),
        .out_side  (fs_side)
    );

    // ---------------- output register
    logic        done_reg;
    rmq_out_t    result_reg;
    rmq_out_t    result_next;
    logic [31:0] qv [4];

    always_comb
    begin
        for (int l = 0; l < 4; l++)
            qv[l] = fs_side[l] ? -(32'(fs_val[l])) : 32'(fs_val[l]);
        if (fs_side[4])
        begin
            result_next.qx         = '0;
            result_next.qy         = '0;
            result_next.qz         = '0;
            result_next.qw         = Q_ONE;
            result_next.degenerate = 1'b1;
        end
        else
        begin
            result_next.qx         = qv[LANE_X];
            result_next.qy         = qv[LANE_Y];
            result_next.qz         = qv[LANE_Z];
            result_next.qw         = qv[LANE_W];
            result_next.degenerate = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // valid bits travel with the data; nothing ever holds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            v8_reg   <= 1'b0;
            v9_reg   <= 1'b0;
            v10_reg  <= 1'b0;
            v11_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= start;
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
            v3_reg   <= col_vld[0];
            v5_reg   <= brs_vld;
            v6_reg   <= dv_vld;
            v7_reg   <= v6_reg;
            v8_reg   <= v7_reg;
            v9_reg   <= v8_reg;
            v10_reg  <= v9_reg;
            v11_reg  <= v10_reg;
            done_reg <= fs_vld;
        end
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    // ---------------- checks
    a_cols_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (col_vld[0] == col_vld[1]) && (col_vld[0] == col_vld[2]))
        else $error("column scalers out of step");

    a_cols_deg: assert property (@(posedge clk) disable iff (!rst_n)
        col_vld[0] |-> (col_side[0][3] == col_side[1][3]) &&
                       (col_side[0][3] == col_side[2][3]))
        else $error("column scalers carry different requests");

    a_ident: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.degenerate) |-> (result.qx == 0) && (result.qy == 0) &&
                                        (result.qz == 0) && (result.qw == Q_ONE))
        else $error("degenerate result is not the identity");

    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.degenerate) |->
            ((result.qx | result.qy | result.qz | result.qw) != 0))
        else $error("normalized result collapsed to zero");

    a_v6_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        v7_reg |-> $past(dv_vld, 2))
        else $error("renormalize stage valid without a division result");

endmodule

`default_nettype wire

// File: rtl/rmq_isqrt.sv
// Pipelined integer square root, two radicand bits per stage, with a side
// payload that travels alongside. No package dependencies.
`default_nettype none

module rmq_isqrt #(
    parameter int IW = 64,
    parameter int SW = 1
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    input  wire [IW-1:0]     in_val,
    input  wire [SW-1:0]     in_side,
    output logic             out_valid,
    output logic [IW/2-1:0]  out_root,
    output logic [SW-1:0]    out_side
);

    localparam int ST = IW / 2;
    localparam int RW = ST + 3;

    logic          vld_reg  [ST];
    logic [RW-1:0] rem_reg  [ST];
    logic [ST-1:0] root_reg [ST];
    logic [IW-1:0] x_reg    [ST];
    logic [SW-1:0] side_reg [ST];

    genvar g;
    generate
        for (g = 0; g < ST; g++)
        begin : g_stage
            logic          prev_vld;
            logic [RW-1:0] prev_rem;
            logic [ST-1:0] prev_root;
            logic [IW-1:0] prev_x;
            logic [SW-1:0] prev_side;
            logic [RW-1:0] rem_t;
            logic [RW-1:0] trial;
            logic [RW-1:0] rem_next;
            logic [ST-1:0] root_next;
            logic [IW-1:0] x_next;

            if (g == 0)
            begin : g_first
                assign prev_vld  = in_valid;
                assign prev_rem  = '0;
                assign prev_root = '0;
                assign prev_x    = in_val;
                assign prev_side = in_side;
            end
            else
            begin : g_later
                assign prev_vld  = vld_reg[g-1];
                assign prev_rem  = rem_reg[g-1];
                assign prev_root = root_reg[g-1];
                assign prev_x    = x_reg[g-1];
                assign prev_side = side_reg[g-1];
            end

            always_comb
            begin
                rem_t  = {prev_rem[RW-3:0], prev_x[IW-1 -: 2]};
                trial  = {1'b0, prev_root, 2'b01};
                x_next = prev_x << 2;
                if (rem_t >= trial)
                begin
                    rem_next  = rem_t - trial;
                    root_next = {prev_root[ST-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_t;
                    root_next = {prev_root[ST-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[g] <= 1'b0;
                else
                    vld_reg[g] <= prev_vld;
            end

            always_ff @(posedge clk)
            begin
                rem_reg[g]  <= rem_next;
                root_reg[g] <= root_next;
                x_reg[g]    <= x_next;
                side_reg[g] <= prev_side;
            end
        end
    endgenerate

    assign out_valid = vld_reg[ST-1];
    assign out_root  = root_reg[ST-1];
    assign out_side  = side_reg[ST-1];

endmodule

`default_nettype wire

// File: rtl/rmq_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor, with a side payload. No package dependencies.
`default_nettype none

module rmq_div #(
    parameter int LANES = 1,
    parameter int NW    = 64,
    parameter int DW    = 32,
    parameter int QW    = 32,
    parameter int SW    = 1
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        in_valid,
    input  wire [LANES-1:0][NW-1:0]    in_num,
    input  wire [DW-1:0]               in_den,
    input  wire [SW-1:0]               in_side,
    output logic                       out_valid,
    output logic [LANES-1:0][QW-1:0]   out_quo,
    output logic [SW-1:0]              out_side
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic                     vld_reg  [QW];
    logic [LANES-1:0][CW-1:0] rem_reg  [QW];
    logic [LANES-1:0][QW-1:0] quo_reg  [QW];
    logic [DW-1:0]            den_reg  [QW];
    logic [SW-1:0]            side_reg [QW];

    genvar g;
    generate
        for (g = 0; g < QW; g++)
        begin : g_stage
            localparam int SH = QW - 1 - g;
            logic                     prev_vld;
            logic [LANES-1:0][CW-1:0] prev_rem;
            logic [LANES-1:0][QW-1:0] prev_quo;
            logic [DW-1:0]            prev_den;
            logic [SW-1:0]            prev_side;
            logic [CW-1:0]            sub;
            logic [LANES-1:0][CW-1:0] rem_next;
            logic [LANES-1:0][QW-1:0] quo_next;

            if (g == 0)
            begin : g_first
                always_comb
                begin
                    for (int l = 0; l < LANES; l++)
                        prev_rem[l] = CW'(in_num[l]);
                end
                assign prev_vld  = in_valid;
                assign prev_quo  = '0;
                assign prev_den  = in_den;
                assign prev_side = in_side;
            end
            else
            begin : g_later
                assign prev_vld  = vld_reg[g-1];
                assign prev_rem  = rem_reg[g-1];
                assign prev_quo  = quo_reg[g-1];
                assign prev_den  = den_reg[g-1];
                assign prev_side = side_reg[g-1];
            end

            always_comb
            begin
                sub = CW'(prev_den) << SH;
                for (int l = 0; l < LANES; l++)
                begin
                    if (prev_rem[l] >= sub)
                    begin
                        rem_next[l] = prev_rem[l] - sub;
                        quo_next[l] = {prev_quo[l][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[l] = prev_rem[l];
                        quo_next[l] = {prev_quo[l][QW-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[g] <= 1'b0;
                else
                    vld_reg[g] <= prev_vld;
            end

            always_ff @(posedge clk)
            begin
                rem_reg[g]  <= rem_next;
                quo_reg[g]  <= quo_next;
                den_reg[g]  <= prev_den;
                side_reg[g] <= prev_side;
            end
        end
    endgenerate

    assign out_valid = vld_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

`default_nettype wire

// File: rtl/rmq_uscale.sv
// Scales magnitudes by 1/sqrt(len) to F fraction bits, rounding half up.
// Depends on rmq_pkg, rmq_isqrt and rmq_div.
`default_nettype none

module rmq_uscale
    import rmq_pkg::*;
#(
    parameter int N  = 3,
    parameter int AW = 32,
    parameter int F  = 30,
    parameter int SW = 1
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    input  wire [63:0]              in_len,
    input  wire [N-1:0][AW-1:0]     in_mag,
    input  wire [SW-1:0]            in_side,
    output logic                    out_valid,
    output logic [N-1:0][F:0]       out_val,
    output logic [SW-1:0]           out_side
);

    localparam int NW = 33 + F;

    // stage 1: leading zero count of the length
    logic                 v1_reg;
    logic [63:0]          len1_reg;
    logic [N-1:0][AW-1:0] mag1_reg;
    logic [SW-1:0]        side1_reg;
    logic [6:0]           lz1_reg;

    // stage 2: shift length up by 2k, magnitudes by k
    logic                 v2_reg;
    logic [63:0]          len2_reg;
    logic [N-1:0][63:0]   ak2_reg;
    logic [SW-1:0]        side2_reg;
    logic [5:0]           k2;
    logic [63:0]          len2_next;
    logic [N-1:0][63:0]   ak2_next;

    logic                 sq_valid;
    logic [31:0]          sq_root;
    logic [N*64+SW-1:0]   sq_side;
    logic [N-1:0][63:0]   sq_ak;

    // stage 3: clamp and build the rounded numerators
    logic                 v3_reg;
    logic [N-1:0][NW-1:0] num3_reg;
    logic [31:0]          t3_reg;
    logic [SW-1:0]        side3_reg;
    logic [N-1:0][NW-1:0] num3_next;

    always_comb
    begin
        k2        = lz1_reg[6:1];
        len2_next = len1_reg << {k2, 1'b0};
        for (int l = 0; l < N; l++)
            ak2_next[l] = 64'(mag1_reg[l]) << k2;
    end

    always_comb
    begin
        for (int l = 0; l < N; l++)
        begin
            if (sq_ak[l] < 64'(sq_root))
                num3_next[l] = (NW'(sq_ak[l][31:0]) << F) + NW'(sq_root >> 1);
            else
                num3_next[l] = (NW'(sq_root) << F) + NW'(sq_root >> 1);
        end
    end

    assign sq_ak = sq_side[N*64+SW-1:SW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        len1_reg  <= in_len;
        mag1_reg  <= in_mag;
        side1_reg <= in_side;
        lz1_reg   <= lzc64(in_len);
        len2_reg  <= len2_next;
        ak2_reg   <= ak2_next;
        side2_reg <= side1_reg;
        num3_reg  <= num3_next;
        t3_reg    <= sq_root;
        side3_reg <= sq_side[SW-1:0];
    end

    rmq_isqrt #(
        .IW (64),
        .SW (N*64 + SW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .in_val    (len2_reg),
        .in_side   ({ak2_reg, side2_reg}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    rmq_div #(
        .LANES (N),
        .NW    (NW),
        .DW    (32),
        .QW    (F + 1),
        .SW    (SW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .in_num    (num3_reg),
        .in_den    (t3_reg),
        .in_side   (side3_reg),
        .out_valid (out_valid),
        .out_quo   (out_val),
        .out_side  (out_side)
    );

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for rotation_matrix_to_quaternion_top: Shepperd matrix-to-quaternion.
// Depends on rmq_pkg and the RTL top level; predicts each result in integer arithmetic.
`default_nettype none

module testbench;
    import rmq_pkg::*;

    localparam int OUT_FRAC   = 30;
    localparam int LATENCY    = 192 + OUT_FRAC;
    localparam longint LIMIT  = 400000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    rmq_in_t  matrix;
    logic     done;
    rmq_out_t result;

    rmq_in_t  pending_requests[$];
    rmq_out_t expected_quats[$];
    int       sender_idle_pct;
    int       mismatches;
    longint   cycle_count;

    rotation_matrix_to_quaternion_top #(.OUT_FRAC_BITS(OUT_FRAC)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .matrix(matrix), .done(done), .result(result)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // round(a * 2^frac / sqrt(len)), halves up
    function automatic logic [63:0] norm_scale(input logic [63:0] a, input logic [63:0] len,
                                               input int frac);
        int          k;
        logic [63:0] t;
        logic [63:0] n;
        logic [127:0] num;
        k = 0;
        while (len < (64'd1 << 62))
        begin
            len = len << 2;
            k++;
        end
        t = int_sqrt(len);
        n = a << k;
        if (n > t)
            n = t;
        num = ({64'd0, n} << frac) + (t >> 1);
        return 64'(num / t);
    endfunction

    function automatic longint div_by_root(input longint d, input logic [63:0] s);
        logic [63:0]  mag;
        logic [127:0] num;
        if (s == 0)
            return 0;
        mag = (d < 0) ? 64'(-d) : 64'(d);
        num = ({64'd0, mag} << WORK_FRAC) + (s >> 1);
        mag = 64'(num / s);
        return (d < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic logic [63:0] double_root(input longint v);
        if (v <= 0)
            return 0;
        return 2 * int_sqrt(64'(v) << WORK_FRAC);
    endfunction

    function automatic rmq_out_t identity_quat();
        rmq_out_t o;
        o = '0;
        o.qw = 32'(64'd1 << OUT_FRAC);
        o.degenerate = 1'b1;
        return o;
    endfunction

    function automatic rmq_out_t predict_quat(input rmq_in_t mi);
        longint      m[3][3];
        longint      r[3][3];
        longint      q[4];
        logic [63:0] mg[4];
        logic [63:0] big;
        logic [63:0] len;
        logic [63:0] s;
        logic [63:0] col;
        longint      tr;
        longint      one;
        logic [63:0] mag;
        rmq_out_t    o;
        one = longint'(1) << WORK_FRAC;
        m[0][0] = mi.m00; m[0][1] = mi.m01; m[0][2] = mi.m02;
        m[1][0] = mi.m10; m[1][1] = mi.m11; m[1][2] = mi.m12;
        m[2][0] = mi.m20; m[2][1] = mi.m21; m[2][2] = mi.m22;
        for (int j = 0; j < 3; j++)
        begin
            col = 0;
            for (int i = 0; i < 3; i++)
            begin
                mag = (m[i][j] < 0) ? 64'(-m[i][j]) : 64'(m[i][j]);
                col = col + mag * mag;
            end
            if (col == 0)
                return identity_quat();
            for (int i = 0; i < 3; i++)
            begin
                mag = (m[i][j] < 0) ? 64'(-m[i][j]) : 64'(m[i][j]);
                mag = norm_scale(mag, col, WORK_FRAC);
                r[i][j] = (m[i][j] < 0) ? -longint'(mag) : longint'(mag);
            end
        end
        tr = r[0][0] + r[1][1] + r[2][2];
        if (tr > 0)
        begin
            s = double_root(tr + one);
            q[3] = longint'((s + 2) >> 2);
            q[0] = div_by_root(r[2][1] - r[1][2], s);
            q[1] = div_by_root(r[0][2] - r[2][0], s);
            q[2] = div_by_root(r[1][0] - r[0][1], s);
        end
        else if (r[0][0] > r[1][1] && r[0][0] > r[2][2])
        begin
            s = double_root(one + r[0][0] - r[1][1] - r[2][2]);
            q[3] = div_by_root(r[2][1] - r[1][2], s);
            q[0] = longint'((s + 2) >> 2);
            q[1] = div_by_root(r[0][1] + r[1][0], s);
            q[2] = div_by_root(r[0][2] + r[2][0], s);
        end
        else if (r[1][1] > r[2][2])
        begin
            s = double_root(one + r[1][1] - r[0][0] - r[2][2]);
            q[3] = div_by_root(r[0][2] - r[2][0], s);
            q[0] = div_by_root(r[0][1] + r[1][0], s);
            q[1] = longint'((s + 2) >> 2);
            q[2] = div_by_root(r[1][2] + r[2][1], s);
        end
        else
        begin
            s = double_root(one + r[2][2] - r[0][0] - r[1][1]);
            q[3] = div_by_root(r[1][0] - r[0][1], s);
            q[0] = div_by_root(r[0][2] + r[2][0], s);
            q[1] = div_by_root(r[1][2] + r[2][1], s);
            q[2] = longint'((s + 2) >> 2);
        end
        big = 0;
        for (int i = 0; i < 4; i++)
        begin
            mg[i] = (q[i] < 0) ? 64'(-q[i]) : 64'(q[i]);
            if (mg[i] > big)
                big = mg[i];
        end
        if (big == 0)
            return identity_quat();
        while (big >= (64'd1 << 31))
        begin
            big = big >> 1;
            for (int i = 0; i < 4; i++)
                mg[i] = mg[i] >> 1;
        end
        while (big < (64'd1 << 30))
        begin
            big = big << 1;
            for (int i = 0; i < 4; i++)
                mg[i] = mg[i] << 1;
        end
        len = 0;
        for (int i = 0; i < 4; i++)
            len = len + mg[i] * mg[i];
        for (int i = 0; i < 4; i++)
        begin
            mag = norm_scale(mg[i], len, OUT_FRAC);
            mg[i] = (q[i] < 0) ? -mag : mag;
        end
        o.qx = mg[0][31:0];
        o.qy = mg[1][31:0];
        o.qz = mg[2][31:0];
        o.qw = mg[3][31:0];
        o.degenerate = 1'b0;
        return o;
    endfunction

    function automatic logic [31:0] rand_entry();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 131072)) - 65536);
            2: return 32'(int'($urandom_range(0, 20)) - 10);
            3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            4: return 32'd0;
            default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    function automatic rmq_in_t scaled_rotation();
        rmq_in_t mi;
        logic signed [31:0] k;
        logic signed [31:0] c;
        logic signed [31:0] sn;
        int                 axis;
        k    = 32'($urandom_range(1, 1 << 14));
        c    = 32'(int'($urandom_range(0, 2 * 4096)) - 4096);
        sn   = 32'(int'($urandom_range(0, 2 * 4096)) - 4096);
        axis = $urandom_range(0, 3);
        mi   = '0;
        // planar rotation about one axis, or a signed permutation-like matrix
        case (axis)
            0: begin mi.m00 = k; mi.m11 = c*k; mi.m12 = -sn*k; mi.m21 = sn*k; mi.m22 = c*k; end
            1: begin mi.m11 = k; mi.m00 = c*k; mi.m02 = sn*k; mi.m20 = -sn*k; mi.m22 = c*k; end
            2: begin mi.m22 = k; mi.m00 = c*k; mi.m01 = -sn*k; mi.m10 = sn*k; mi.m11 = c*k; end
            default:
            begin
                mi.m00 = -k; mi.m11 = -k; mi.m22 = k;
                mi.m01 = 32'(int'($urandom_range(0, 2)) - 1);
            end
        endcase
        return mi;
    endfunction

    function automatic rmq_in_t diag(input logic [31:0] a, input logic [31:0] b,
                                     input logic [31:0] c);
        rmq_in_t mi;
        mi = '0;
        mi.m00 = a;
        mi.m11 = b;
        mi.m22 = c;
        return mi;
    endfunction

    initial
    begin
        rmq_in_t mi;
        rst_n = 1'b0;
        start = 1'b0;
        matrix = '0;
        sender_idle_pct = 27;
        // identity, each branch, zero columns, extremes
        pending_requests.push_back(diag(32'h10000, 32'h10000, 32'h10000));
        pending_requests.push_back(diag(32'h10000, -32'h10000, -32'h10000));
        pending_requests.push_back(diag(-32'h10000, 32'h10000, -32'h10000));
        pending_requests.push_back(diag(-32'h10000, -32'h10000, 32'h10000));
        pending_requests.push_back(diag(-32'h10000, -32'h10000, -32'h10000));
        pending_requests.push_back('0);
        pending_requests.push_back(diag(32'd0, 32'd1, 32'd1));
        pending_requests.push_back(diag(32'd1, 32'd1, 32'd0));
        pending_requests.push_back(diag(32'h7fffffff, 32'h80000000, 32'h7fffffff));
        pending_requests.push_back(diag(32'h80000000, 32'h80000000, 32'h80000000));
        pending_requests.push_back({9{32'h7fffffff}});
        pending_requests.push_back({9{32'h80000000}});
        pending_requests.push_back({9{32'hffffffff}});
        pending_requests.push_back({9{32'd1}});
        pending_requests.push_back({9{32'h55555555}});
        pending_requests.push_back({9{32'haaaaaaaa}});
        for (int n = 0; n < 1350; n++)
        begin
            if ($urandom_range(0, 99) < 65)
                mi = scaled_rotation();
            else
                mi = {rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
                      rand_entry(), rand_entry(), rand_entry(), rand_entry()};
            pending_requests.push_back(mi);
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Request driver: change inputs at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                start  <= 1'b1;
                matrix <= pending_requests[0];
            end
            else
            begin
                start  <= 1'b0;
                matrix <= {$urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom};
            end
        end
    end

    int   accepted;

    // Accept requests and check results at the rising edge
    always @(posedge clk)
    begin
        cycle_count  <= cycle_count + 1;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_quats.push_back(predict_quat(matrix));
                void'(pending_requests.pop_front());
                accepted <= accepted + 1;
                if (accepted == 450)
                    sender_idle_pct <= 62;
                else if (accepted == 900)
                    sender_idle_pct <= 0;
            end
            if (done)
            begin
                if (expected_quats.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result %h", result);
                end
                else
                begin
                    if (result !== expected_quats[0])
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: exp x=%h y=%h z=%h w=%h deg=%b,",
                                     expected_quats[0].qx, expected_quats[0].qy,
                                     expected_quats[0].qz, expected_quats[0].qw,
                                     expected_quats[0].degenerate,
                                     " got x=%h y=%h z=%h w=%h deg=%b",
                                     result.qx, result.qy,
                                     result.qz, result.qw, result.degenerate);
                    end
                    void'(expected_quats.pop_front());
                end
            end
        end
    end

    initial
    begin
        mismatches  = 0;
        cycle_count = 0;
        accepted    = 0;
    end

    // Finish when drained, or on timeout
    initial
    begin
        wait (rst_n === 1'b1);
        wait (pending_requests.size() == 0 || cycle_count > LIMIT);
        wait (expected_quats.size() == 0 || cycle_count > LIMIT);
        if (cycle_count <= LIMIT)
            repeat (LATENCY + 20) @(posedge clk);
        if (cycle_count > LIMIT || expected_quats.size() != 0)
            $display("Testbench completed WITH ERRORS");
        else if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
